@@ design/bmms_pkg.sv @@
`timescale 1ns / 1ps

package bmms_pkg;

	// Default sizing of the column store, the coordinate counters and the queue.
	localparam int MAX_COLUMNS_DEF = 4096;
	localparam int COORD_BITS_DEF = 12;
	localparam int QUEUE_DEPTH_DEF = 2;

	// Fixed widths of the port fields.
	localparam int PIXEL_BITS = 8;
	localparam int SPAN_BITS = 12;
	localparam int CFG_BITS = 13;
	localparam int CFG_INDEX_BITS = 2;

	// Register indexes of the configuration port.
	localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_COLUMNS = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_ROWS = 2'd1;

	// Register values after reset.
	localparam logic [CFG_BITS-1:0] FRAME_COLUMNS_RST = 13'd640;
	localparam logic [CFG_BITS-1:0] FRAME_ROWS_RST = 13'd480;

	// Classification of one pixel, passed from the front to the back.
	typedef struct packed {
		logic pix_set;
		logic row_start;
		logic frame_end;
	} bmms_flags_t;

	localparam int FLAGS_BITS = $bits(bmms_flags_t);

endpackage

@@ design/bmms_ram.sv @@
`timescale 1ns / 1ps

module bmms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port; a read of the address being
	// written returns the old word.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ design/bmms_fifo.sv @@
`timescale 1ns / 1ps

module bmms_fifo import bmms_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             push_ready,
	input  logic             pop,
	output logic             pop_valid,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  count_q;

	assign push_ready = (count_q != CNTW'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data = slot_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNTW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ design/bmms_front.sv @@
`timescale 1ns / 1ps

module bmms_front import bmms_pkg::*; #(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]       cfg_data,
	input  logic                      pixel_valid,
	output logic                      pixel_ready,
	input  logic [PIXEL_BITS-1:0]     pixel_value,
	input  logic                      init_done,
	input  logic                      queue_ready,
	output logic                      push,
	output bmms_flags_t               push_flags,
	output logic [COORD_BITS-1:0]     push_col,
	output logic [COORD_BITS-1:0]     push_row
);

	localparam int CW = ((COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS) + 1;
	localparam int COORD_LIMIT = 1 << COORD_BITS;
	localparam int COL_LIMIT = (MAX_COLUMNS < COORD_LIMIT) ? MAX_COLUMNS : COORD_LIMIT;

	logic [CFG_BITS-1:0]   frame_columns_q;
	logic [CFG_BITS-1:0]   frame_rows_q;
	logic [COORD_BITS-1:0] col_q;
	logic [COORD_BITS-1:0] row_q;
	logic [CW-1:0]         cols_raw;
	logic [CW-1:0]         rows_raw;
	logic [CW-1:0]         cols_use;
	logic [CW-1:0]         rows_use;
	logic                  row_end;
	logic                  frame_end;

	assign cfg_ready = 1'b1;
	assign pixel_ready = queue_ready && init_done;
	assign push = pixel_valid && pixel_ready;

	// Frame geometry in use: zero acts as one, large values saturate.
	always_comb begin
		cols_raw = CW'(frame_columns_q);
		rows_raw = CW'(frame_rows_q);
		cols_use = cols_raw;
		rows_use = rows_raw;
		if (cols_raw == '0) begin
			cols_use = CW'(1);
		end else if (cols_raw > CW'(COL_LIMIT)) begin
			cols_use = CW'(COL_LIMIT);
		end
		if (rows_raw == '0) begin
			rows_use = CW'(1);
		end else if (rows_raw > CW'(COORD_LIMIT)) begin
			rows_use = CW'(COORD_LIMIT);
		end
	end

	// A row ends on or past the last column; the frame ends when that
	// happens on or past the last row.
	assign row_end = (CW'(col_q) + CW'(1)) >= cols_use;
	assign frame_end = row_end && ((CW'(row_q) + CW'(1)) >= rows_use);

	assign push_flags.pix_set = (pixel_value != '0);
	assign push_flags.row_start = (col_q == '0);
	assign push_flags.frame_end = frame_end;
	assign push_col = col_q;
	assign push_row = row_q;

	// Configuration registers and raster position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_columns_q <= FRAME_COLUMNS_RST;
			frame_rows_q <= FRAME_ROWS_RST;
			col_q <= '0;
			row_q <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_FRAME_COLUMNS: begin
						frame_columns_q <= cfg_data;
					end
					REG_FRAME_ROWS: begin
						frame_rows_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (push) begin
				if (row_end) begin
					col_q <= '0;
					row_q <= frame_end ? '0 : row_q + COORD_BITS'(1);
				end else begin
					col_q <= col_q + COORD_BITS'(1);
				end
			end
		end
	end

endmodule

@@ design/bmms_back.sv @@
`timescale 1ns / 1ps

module bmms_back import bmms_pkg::*; #(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  queue_valid,
	input  bmms_flags_t           queue_flags,
	input  logic [COORD_BITS-1:0] queue_col,
	input  logic [COORD_BITS-1:0] queue_row,
	output logic                  pop,
	output logic                  init_done,
	output logic                  span_valid,
	input  logic                  span_ready,
	output logic [SPAN_BITS-1:0]  max_row_span,
	output logic [SPAN_BITS-1:0]  max_column_span
);

	localparam int AW = $clog2(MAX_COLUMNS);
	localparam int EW = AW + 1;
	localparam int ENTRY_W = EW + COORD_BITS;
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_COLUMNS - 1);

	// Column store entry: frame tag and first set row. An entry counts as
	// seen only when its tag matches the current frame tag.
	typedef struct packed {
		logic [EW-1:0]         tag;
		logic [COORD_BITS-1:0] first_row;
	} entry_t;

	logic                  init_busy_q;
	logic [AW-1:0]         init_ptr_q;
	logic [EW-1:0]         epoch_q;
	logic [AW-1:0]         scrub_ptr_q;
	logic                  valid_s1;
	bmms_flags_t           flags_s1;
	logic [COORD_BITS-1:0] col_s1;
	logic [COORD_BITS-1:0] row_s1;
	logic                  fwd_valid_q;
	logic [AW-1:0]         fwd_addr_q;
	entry_t                fwd_data_q;
	logic                  row_seen_q;
	logic [COORD_BITS-1:0] row_first_q;
	logic [COORD_BITS-1:0] widest_q;
	logic [COORD_BITS-1:0] tallest_q;
	logic                  span_valid_q;
	logic [SPAN_BITS-1:0]  out_row_q;
	logic [SPAN_BITS-1:0]  out_col_q;

	logic                  stall_s1;
	logic                  done_s1;
	entry_t                rd_entry;
	entry_t                entry;
	logic                  col_seen;
	logic                  row_seen;
	logic [COORD_BITS-1:0] row_span;
	logic [COORD_BITS-1:0] col_span;
	logic [COORD_BITS-1:0] widest_nx;
	logic [COORD_BITS-1:0] tallest_nx;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	entry_t                wr_data;

	bmms_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_COLUMNS)
	) u_column_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (pop),
		.rd_addr(AW'(queue_col)),
		.rd_data(rd_entry)
	);

	// A frame end waits while the previous result has not been taken.
	assign stall_s1 = valid_s1 && flags_s1.frame_end && span_valid_q && !span_ready;
	assign done_s1 = valid_s1 && !stall_s1;
	assign pop = queue_valid && !init_busy_q && (!valid_s1 || done_s1);
	assign init_done = !init_busy_q;

	// Entry lookup, bypassing the word written at the edge of the read.
	assign entry = (fwd_valid_q && (fwd_addr_q == AW'(col_s1))) ? fwd_data_q : rd_entry;
	assign col_seen = (entry.tag == epoch_q);
	assign row_seen = row_seen_q && !flags_s1.row_start;

	// Span candidates and running maxima including the current pixel.
	always_comb begin
		row_span = col_s1 - row_first_q;
		col_span = row_s1 - entry.first_row;
		widest_nx = widest_q;
		tallest_nx = tallest_q;
		if (flags_s1.pix_set && row_seen && (row_span > widest_q)) begin
			widest_nx = row_span;
		end
		if (flags_s1.pix_set && col_seen && (col_span > tallest_q)) begin
			tallest_nx = col_span;
		end
	end

	// Store write: clearing pass after reset, one stale entry per frame end,
	// otherwise the first set row of a column.
	always_comb begin
		wr_en = 1'b0;
		wr_addr = AW'(col_s1);
		wr_data.tag = epoch_q;
		wr_data.first_row = row_s1;
		if (init_busy_q) begin
			wr_en = 1'b1;
			wr_addr = init_ptr_q;
			wr_data.tag = epoch_q - EW'(1);
			wr_data.first_row = '0;
		end else if (done_s1 && flags_s1.frame_end) begin
			wr_en = 1'b1;
			wr_addr = scrub_ptr_q;
			wr_data.first_row = '0;
		end else if (done_s1 && flags_s1.pix_set && !col_seen) begin
			wr_en = 1'b1;
		end
	end

	assign span_valid = span_valid_q;
	assign max_row_span = out_row_q;
	assign max_column_span = out_col_q;

	// Control state, frame state and result handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_busy_q <= 1'b1;
			init_ptr_q <= '0;
			epoch_q <= '0;
			scrub_ptr_q <= '0;
			valid_s1 <= 1'b0;
			fwd_valid_q <= 1'b0;
			row_seen_q <= 1'b0;
			widest_q <= '0;
			tallest_q <= '0;
			span_valid_q <= 1'b0;
		end else begin
			if (init_busy_q) begin
				init_ptr_q <= (init_ptr_q == LAST_ADDR) ? '0 : init_ptr_q + AW'(1);
				if (init_ptr_q == LAST_ADDR) begin
					init_busy_q <= 1'b0;
				end
			end
			if (pop) begin
				valid_s1 <= 1'b1;
				fwd_valid_q <= wr_en;
			end else if (done_s1) begin
				valid_s1 <= 1'b0;
			end
			if (done_s1) begin
				if (flags_s1.frame_end) begin
					row_seen_q <= 1'b0;
					widest_q <= '0;
					tallest_q <= '0;
					epoch_q <= epoch_q + EW'(1);
					scrub_ptr_q <= (scrub_ptr_q == LAST_ADDR) ? '0 : scrub_ptr_q + AW'(1);
				end else begin
					row_seen_q <= row_seen || flags_s1.pix_set;
					widest_q <= widest_nx;
					tallest_q <= tallest_nx;
				end
			end
			if (done_s1 && flags_s1.frame_end) begin
				span_valid_q <= 1'b1;
			end else if (span_ready) begin
				span_valid_q <= 1'b0;
			end
		end
	end

	// Stage payload, bypass word, row start column and result word.
	always_ff @(posedge clk) begin
		if (pop) begin
			flags_s1 <= queue_flags;
			col_s1 <= queue_col;
			row_s1 <= queue_row;
			fwd_addr_q <= wr_addr;
			fwd_data_q <= wr_data;
		end
		if (done_s1 && flags_s1.pix_set && !row_seen) begin
			row_first_q <= col_s1;
		end
		if (done_s1 && flags_s1.frame_end) begin
			out_row_q <= SPAN_BITS'(widest_nx);
			out_col_q <= SPAN_BITS'(tallest_nx);
		end
	end

endmodule

@@ design/binary_mask_max_span.sv @@
`timescale 1ns / 1ps
// The last pixel of a frame passes the queue and the back stage register before the
// result register loads, waiting only while the previous result word has not been taken.
// Throughput: one pixel per cycle outside that wait, set by the single read-modify-write
// of the column store. After reset a clearing pass writes every column store entry,
// during which no pixel is accepted; configuration writes are taken at all times.
// Reset values: 640 columns, 480 rows, running span maxima cleared.

module binary_mask_max_span import bmms_pkg::*; #(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]       cfg_data,
	input  logic                      pixel_valid,
	output logic                      pixel_ready,
	input  logic [PIXEL_BITS-1:0]     pixel_value,
	output logic                      span_valid,
	input  logic                      span_ready,
	output logic [SPAN_BITS-1:0]      max_row_span,
	output logic [SPAN_BITS-1:0]      max_column_span
);

	localparam int QW = FLAGS_BITS + 2 * COORD_BITS;

	logic                  init_done;
	logic                  queue_ready;
	logic                  push;
	bmms_flags_t           push_flags;
	logic [COORD_BITS-1:0] push_col;
	logic [COORD_BITS-1:0] push_row;
	logic                  pop;
	logic                  queue_valid;
	logic [QW-1:0]         queue_word;
	bmms_flags_t           queue_flags;
	logic [COORD_BITS-1:0] queue_col;
	logic [COORD_BITS-1:0] queue_row;

	// Front: configuration, raster position and pixel classification.
	bmms_front #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.pixel_value(pixel_value),
		.init_done  (init_done),
		.queue_ready(queue_ready),
		.push       (push),
		.push_flags (push_flags),
		.push_col   (push_col),
		.push_row   (push_row)
	);

	// Short queue between the front and the back.
	bmms_fifo #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH_DEF)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_flags, push_col, push_row}),
		.push_ready(queue_ready),
		.pop       (pop),
		.pop_valid (queue_valid),
		.pop_data  (queue_word)
	);

	assign queue_flags = queue_word[QW-1 -: FLAGS_BITS];
	assign queue_col = queue_word[2*COORD_BITS-1 -: COORD_BITS];
	assign queue_row = queue_word[COORD_BITS-1:0];

	// Back: column store, span maxima and the result word.
	bmms_back #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.queue_valid    (queue_valid),
		.queue_flags    (queue_flags),
		.queue_col      (queue_col),
		.queue_row      (queue_row),
		.pop            (pop),
		.init_done      (init_done),
		.span_valid     (span_valid),
		.span_ready     (span_ready),
		.max_row_span   (max_row_span),
		.max_column_span(max_column_span)
	);

endmodule
